FILE: rtl/core/mwo_pkg.sv
// Shared constants, codes and types for the multi-waveform oscillator.
package mwo_pkg;

    // Phase accumulator width (fraction of one cycle)
    localparam int PHASE_BITS = 16;

    // Fixed field widths
    localparam int STEP_W   = 16;
    localparam int WAVE_W   = 3;
    localparam int SAMPLE_W = 16;
    localparam int LFSR_W   = 15;
    localparam int LEVEL_W  = 2;

    // Signed working width for waveform numerators (up to 96 * unit with wrap)
    localparam int NUM_W = PHASE_BITS + 7;

    // Noise generator seed
    localparam logic [LFSR_W-1:0] NOISE_SEED = 15'h5205;

    // Full scale output, +1.0 maps here
    localparam logic signed [SAMPLE_W-1:0] FULL_SCALE = 16'sd32767;

    // Waveform selector codes
    localparam logic [WAVE_W-1:0] WF_TRIANGLE = 3'd0;
    localparam logic [WAVE_W-1:0] WF_TILTED   = 3'd1;
    localparam logic [WAVE_W-1:0] WF_SAW      = 3'd2;
    localparam logic [WAVE_W-1:0] WF_SQUARE   = 3'd3;
    localparam logic [WAVE_W-1:0] WF_PULSE    = 3'd4;
    localparam logic [WAVE_W-1:0] WF_ORGAN    = 3'd5;
    localparam logic [WAVE_W-1:0] WF_NOISE    = 3'd6;
    localparam logic [WAVE_W-1:0] WF_PHASER   = 3'd7;

    // Held noise level codes
    localparam logic [LEVEL_W-1:0] NOISE_SILENT = 2'd0;
    localparam logic [LEVEL_W-1:0] NOISE_HIGH   = 2'd1;
    localparam logic [LEVEL_W-1:0] NOISE_LOW    = 2'd2;

    // One request as held in the input register
    typedef struct packed {
        logic [STEP_W-1:0] phase_step;
        logic [WAVE_W-1:0] waveform;
        logic              restart;
    } item_t;

    // Updated voice state handed to the waveform shaper
    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic [WAVE_W-1:0]     waveform;
        logic [LEVEL_W-1:0]    noise_level;
    } voice_view_t;

endpackage

FILE: rtl/core/mwo_voice.sv
// Voice state: phase accumulator, noise LFSR and held noise level.
module mwo_voice (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  mwo_pkg::item_t      item,
    output mwo_pkg::voice_view_t view
);

    localparam int P = mwo_pkg::PHASE_BITS;

    logic [P-1:0]                   phase_reg;
    logic [P-1:0]                   phase_next;
    logic [mwo_pkg::LFSR_W-1:0]     noise_shift_reg;
    logic [mwo_pkg::LFSR_W-1:0]     noise_shift_next;
    logic [mwo_pkg::LEVEL_W-1:0]    noise_level_reg;
    logic [mwo_pkg::LEVEL_W-1:0]    noise_level_next;

    logic [P-1:0]                   phase_base;
    logic [mwo_pkg::LFSR_W-1:0]     shift_base;
    logic [mwo_pkg::LEVEL_W-1:0]    level_base;
    logic [P+mwo_pkg::STEP_W-1:0]   step_wide;
    logic [P-1:0]                   step_aligned;
    logic [P:0]                     phase_sum;
    logic                           wrapped;
    logic                           fb_bit;

    // Restart clears the voice before the step is applied
    assign phase_base = item.restart ? '0 : phase_reg;
    assign shift_base = item.restart ? mwo_pkg::NOISE_SEED : noise_shift_reg;
    assign level_base = item.restart ? mwo_pkg::NOISE_SILENT : noise_level_reg;

    // Align the 0.16 step to the accumulator width
    assign step_wide    = {item.phase_step, {P{1'b0}}};
    assign step_aligned = step_wide[P+mwo_pkg::STEP_W-1:mwo_pkg::STEP_W];

    // Accumulate; carry out is a wrap
    assign phase_sum  = {1'b0, phase_base} + {1'b0, step_aligned};
    assign wrapped    = phase_sum[P];
    assign phase_next = phase_sum[P-1:0];

    // Noise LFSR steps only on a wrap while noise is selected
    assign fb_bit = shift_base[0] ^ shift_base[1];

    always_comb
    begin
        noise_shift_next = shift_base;
        noise_level_next = level_base;
        if (item.waveform == mwo_pkg::WF_NOISE && wrapped)
        begin
            noise_shift_next = {fb_bit, shift_base[mwo_pkg::LFSR_W-1:1]};
            noise_level_next = shift_base[1] ? mwo_pkg::NOISE_HIGH : mwo_pkg::NOISE_LOW;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= '0;
            noise_shift_reg <= mwo_pkg::NOISE_SEED;
            noise_level_reg <= mwo_pkg::NOISE_SILENT;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            noise_shift_reg <= noise_shift_next;
            noise_level_reg <= noise_level_next;
        end
    end

    assign view.phase       = phase_next;
    assign view.waveform    = item.waveform;
    assign view.noise_level = noise_level_next;

endmodule

FILE: rtl/core/mwo_shape.sv
// Waveform shaper: maps phase and selector to a saturated Q1.15 sample.
module mwo_shape (
    input  mwo_pkg::voice_view_t              view,
    output logic signed [mwo_pkg::SAMPLE_W-1:0] sample
);

    localparam int P  = mwo_pkg::PHASE_BITS;
    localparam int NW = mwo_pkg::NUM_W;
    localparam int MW = P + 5;
    localparam int PW = MW + 15;

    // Scaling modes
    localparam logic [1:0] MODE_UNIT   = 2'd0;
    localparam logic [1:0] MODE_HALF   = 2'd1;
    localparam logic [1:0] MODE_TILT   = 2'd2;
    localparam logic [1:0] MODE_EIGHTH = 2'd3;

    // Phase multiples as signed constants
    localparam logic signed [NW-1:0] UNIT   = {{(NW-P-1){1'b0}}, 1'b1, {P{1'b0}}};
    localparam logic signed [NW-1:0] UNIT7  = (UNIT <<< 3) - UNIT;
    localparam logic signed [NW-1:0] UNIT15 = (UNIT <<< 4) - UNIT;
    localparam logic signed [NW-1:0] UNIT16 = UNIT <<< 4;
    localparam logic signed [NW-1:0] UNIT24 = (UNIT <<< 4) + (UNIT <<< 3);

    // 32767 / 7 exactly, and ceil(2^18 / 3) for the divide by three
    localparam logic [12:0] TILT_GAIN  = 13'd4681;
    localparam logic [16:0] THIRD_RECIP = 17'd87382;

    // Triangle numerator of x within period w (value = result / w)
    function automatic logic signed [NW-1:0] tri_num(
        input logic signed [NW-1:0] x,
        input logic signed [NW-1:0] w
    );
        if ((x <<< 1) < w)
            return (x <<< 2) - w;
        else
            return (w <<< 1) + w - (x <<< 2);
    endfunction

    logic signed [NW-1:0]           t_s;
    logic signed [NW-1:0]           t2_s;
    logic signed [NW-1:0]           tri_t;
    logic signed [NW-1:0]           tri_t2;
    logic signed [NW-1:0]           organ_num;
    logic signed [NW-1:0]           tilt_lo;
    logic signed [NW-1:0]           tilt_hi;
    logic signed [NW-1:0]           saw_num;
    logic signed [NW-1:0]           t25;
    logic signed [NW-1:0]           ph_d;
    logic signed [NW-1:0]           ph_dw;
    logic signed [NW-1:0]           ph_num;

    logic signed [NW-1:0]           num;
    logic [1:0]                     mode;
    logic                           direct;
    logic signed [mwo_pkg::SAMPLE_W-1:0] direct_val;

    logic                           neg;
    logic signed [NW-1:0]           abs_num;
    logic [MW-1:0]                  mag;
    logic [PW-1:0]                  prod_full;
    logic [MW+12:0]                 prod_tilt;
    logic [PW-1:0]                  prod;
    logic [16:0]                    q_eighth;
    logic [33:0]                    third_prod;
    logic [14:0]                    mag_out;
    logic signed [mwo_pkg::SAMPLE_W-1:0] s_mag;

    // Candidate numerators
    assign t_s       = {{(NW-P){1'b0}}, view.phase};
    assign t2_s      = {{(NW-P){1'b0}}, view.phase[P-2:0], 1'b0};
    assign tri_t     = tri_num(t_s, UNIT);
    assign tri_t2    = tri_num(t2_s, UNIT);
    assign organ_num = tri_t + tri_t2;
    assign tilt_lo   = (t_s <<< 4) - UNIT7;
    assign tilt_hi   = (t_s <<< 4) - UNIT15;
    assign saw_num   = (t_s <<< 1) - UNIT;

    // Phaser: 25t - 16 wrapped into one period of 24 units
    assign t25    = (t_s <<< 4) + (t_s <<< 3) + t_s;
    assign ph_d   = t25 - UNIT16;
    assign ph_dw  = ph_d[NW-1] ? ph_d + UNIT24 : ph_d;
    assign ph_num = tri_num(ph_dw, UNIT24);

    // Waveform select
    always_comb
    begin
        num        = tri_t;
        mode       = MODE_UNIT;
        direct     = 1'b0;
        direct_val = '0;
        unique case (view.waveform)
            mwo_pkg::WF_TRIANGLE:
            begin
                num  = tri_t;
                mode = MODE_UNIT;
            end
            mwo_pkg::WF_TILTED:
            begin
                if ((t_s <<< 3) < UNIT7)
                begin
                    num  = tilt_lo;
                    mode = MODE_TILT;
                end
                else
                begin
                    num  = tilt_hi;
                    mode = MODE_UNIT;
                end
            end
            mwo_pkg::WF_SAW:
            begin
                num  = saw_num;
                mode = MODE_UNIT;
            end
            mwo_pkg::WF_SQUARE:
            begin
                direct     = 1'b1;
                direct_val = view.phase[P-1] ? -mwo_pkg::FULL_SCALE : mwo_pkg::FULL_SCALE;
            end
            mwo_pkg::WF_PULSE:
            begin
                direct     = 1'b1;
                direct_val = (view.phase[P-1:P-2] == 2'b00) ?
                             mwo_pkg::FULL_SCALE : -mwo_pkg::FULL_SCALE;
            end
            mwo_pkg::WF_ORGAN:
            begin
                num  = organ_num;
                mode = MODE_HALF;
            end
            mwo_pkg::WF_NOISE:
            begin
                direct = 1'b1;
                case (view.noise_level)
                    mwo_pkg::NOISE_HIGH: direct_val = mwo_pkg::FULL_SCALE;
                    mwo_pkg::NOISE_LOW:  direct_val = -mwo_pkg::FULL_SCALE;
                    default:             direct_val = '0;
                endcase
            end
            mwo_pkg::WF_PHASER:
            begin
                num  = ph_num;
                mode = MODE_EIGHTH;
            end
        endcase
    end

    // Magnitude times full scale (32767 = 2^15 - 1), or times 4681 for the tilt ramp
    assign neg       = num[NW-1];
    assign abs_num   = neg ? -num : num;
    assign mag       = abs_num[MW-1:0];
    assign prod_full = {mag, 15'd0} - {15'd0, mag};
    assign prod_tilt = (MW+13)'(mag) * (MW+13)'(TILT_GAIN);
    assign prod      = (mode == MODE_TILT) ? {2'b00, prod_tilt} : prod_full;

    // Phaser: drop the power of two, then divide by three via reciprocal
    assign q_eighth   = prod[P+19:P+3];
    assign third_prod = 34'(q_eighth) * 34'(THIRD_RECIP);

    // Truncating scale back to Q1.15 magnitude
    always_comb
    begin
        case (mode) inside
            MODE_UNIT, MODE_TILT: mag_out = prod[P+14:P];
            MODE_HALF:            mag_out = prod[P+15:P+1];
            default:              mag_out = third_prod[32:18];
        endcase
    end

    assign s_mag  = {1'b0, mag_out};
    assign sample = direct ? direct_val : (neg ? -s_mag : s_mag);

endmodule

FILE: rtl/core/multi_waveform_oscillator_top.sv
// Top level of the multi-waveform oscillator voice with stream ports.
//
// One synthesizer voice: each request carries a phase step, a waveform
// selector and a restart flag, and yields one signed Q1.15 sample. A request
// is captured in an input register; the voice state update and waveform
// evaluation run from that register once the output slot is free and land in
// the output register. One request per clock is sustained while the output
// side does not stall: the phase accumulator and noise LFSR close their
// feedback through their own state registers alone. While a sample waits on
// the output side, the input register still takes one more request; the
// input then stalls until the waiting sample is taken. There is no memory and
// no start-up clearing; the voice is usable right after reset.
module multi_waveform_oscillator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] phase_step
    input  logic [3:0]  s_axis_tuser,   // [2:0] waveform, [3] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] sample
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    mwo_pkg::item_t         item_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic signed [mwo_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [mwo_pkg::SAMPLE_W-1:0] sample_next;

    logic                   in_accept;
    logic                   advance;
    mwo_pkg::voice_view_t   view;

    // Handshake: the held request moves on when the output slot is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (in_accept)
        begin
            item_reg.phase_step <= s_axis_tdata;
            item_reg.waveform   <= s_axis_tuser[2:0];
            item_reg.restart    <= s_axis_tuser[3];
        end
    end

    // Voice state and waveform
    mwo_voice u_voice (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .view    (view)
    );

    mwo_shape u_shape (
        .view   (view),
        .sample (sample_next)
    );

    // Output sample register
    always_ff @(posedge clk)
    begin
        if (advance)
            sample_reg <= sample_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = sample_reg;

    // A request moved into the output slot shows up as a valid sample
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("sample missing after request advanced");

    // An accepted request is held in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_valid_reg)
        else $error("accepted request not held");

    // A stalled sample is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !advance)
        else $error("stalled sample overwritten");

    // Saturation keeps the most negative code out of the stream
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (sample_reg != 16'sh8000))
        else $error("sample outside +/-32767");

endmodule

FILE: verif/multi_waveform_oscillator_top_test.sv
// Self-checking stream testbench for the multi-waveform oscillator voice.
`timescale 1ns / 1ps

module multi_waveform_oscillator_top_test;

    localparam int RUN_LIMIT    = 200000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_AFTER   = 400;   // requests taken before the long output hold
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 8;
    localparam int DIRECTED_N   = 24;

    // Output-side stall patterns
    localparam int SINK_OPEN   = 0;
    localparam int SINK_RANDOM = 1;
    localparam int SINK_SPARSE = 2;
    localparam int SINK_STROBE = 3;

    localparam logic signed [mwo_pkg::SAMPLE_W-1:0] NEG_FULL = -mwo_pkg::FULL_SCALE;
    localparam logic signed [mwo_pkg::SAMPLE_W-1:0] ZERO_OUT = '0;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] phase_step
    logic [3:0]  s_axis_tuser;   // [2:0] waveform, [3] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] sample

    // Directed stimulus row; fixed_sample is used when has_fixed is set
    typedef struct packed {
        logic [mwo_pkg::STEP_W-1:0]          phase_step;
        logic [mwo_pkg::WAVE_W-1:0]          waveform;
        logic                                restart;
        logic                                has_fixed;
        logic signed [mwo_pkg::SAMPLE_W-1:0] fixed_sample;
    } stim_row_t;

    stim_row_t directed_rows [0:DIRECTED_N-1] = '{
        // restart, bottom of triangle
        '{16'h0000, mwo_pkg::WF_TRIANGLE, 1'b1, 1'b1, NEG_FULL},
        // triangle peak at half cycle
        '{16'h8000, mwo_pkg::WF_TRIANGLE, 1'b0, 1'b1, mwo_pkg::FULL_SCALE},
        // wrap back to zero phase
        '{16'h8000, mwo_pkg::WF_SAW,      1'b0, 1'b1, NEG_FULL},
        '{16'h0000, mwo_pkg::WF_SQUARE,   1'b0, 1'b1, mwo_pkg::FULL_SCALE},
        // pulse edge at quarter cycle
        '{16'h4000, mwo_pkg::WF_PULSE,    1'b0, 1'b1, NEG_FULL},
        // largest step, wraps
        '{16'hFFFF, mwo_pkg::WF_PULSE,    1'b0, 1'b1, mwo_pkg::FULL_SCALE},
        // square edge at half cycle
        '{16'h4001, mwo_pkg::WF_SQUARE,   1'b0, 1'b1, NEG_FULL},
        // top of saw
        '{16'h7FFF, mwo_pkg::WF_SAW,      1'b0, 1'b0, ZERO_OUT},
        // tilted saw second ramp start
        '{16'hE000, mwo_pkg::WF_TILTED,   1'b1, 1'b1, NEG_FULL},
        '{16'h1FFF, mwo_pkg::WF_TILTED,   1'b0, 1'b0, ZERO_OUT},
        '{16'h0000, mwo_pkg::WF_ORGAN,    1'b1, 1'b1, NEG_FULL},
        '{16'h4000, mwo_pkg::WF_ORGAN,    1'b0, 1'b0, ZERO_OUT},
        '{16'h8000, mwo_pkg::WF_ORGAN,    1'b0, 1'b0, ZERO_OUT},
        '{16'h0000, mwo_pkg::WF_PHASER,   1'b1, 1'b0, ZERO_OUT},
        '{16'hFFFF, mwo_pkg::WF_PHASER,   1'b0, 1'b0, ZERO_OUT},
        '{16'h5555, mwo_pkg::WF_PHASER,   1'b0, 1'b0, ZERO_OUT},
        // silent after restart
        '{16'h0000, mwo_pkg::WF_NOISE,    1'b1, 1'b1, ZERO_OUT},
        // no wrap yet, still silent
        '{16'hFFFF, mwo_pkg::WF_NOISE,    1'b0, 1'b1, ZERO_OUT},
        // first shift clears bit 0
        '{16'hFFFF, mwo_pkg::WF_NOISE,    1'b0, 1'b1, NEG_FULL},
        // second shift sets bit 0
        '{16'hFFFF, mwo_pkg::WF_NOISE,    1'b0, 1'b1, mwo_pkg::FULL_SCALE},
        // zero step holds the level
        '{16'h0000, mwo_pkg::WF_NOISE,    1'b0, 1'b1, mwo_pkg::FULL_SCALE},
        '{16'h0001, mwo_pkg::WF_TRIANGLE, 1'b0, 1'b0, ZERO_OUT},
        // restart silences held noise
        '{16'hFFFF, mwo_pkg::WF_NOISE,    1'b1, 1'b1, ZERO_OUT},
        '{16'hFFFF, mwo_pkg::WF_SAW,      1'b0, 1'b0, ZERO_OUT}
    };

    // Voice state mirror
    longint                         voice_phase;
    logic [mwo_pkg::LFSR_W-1:0]     voice_lfsr;
    logic [mwo_pkg::LEVEL_W-1:0]    voice_level;

    logic signed [mwo_pkg::SAMPLE_W-1:0] expected_samples [$];
    int unsigned cycle_count;
    int unsigned requests_taken;
    int unsigned mismatch_count;
    int unsigned burst_left;
    bit          hold_done;

    multi_waveform_oscillator_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Triangle numerator for position x in period w (value = result / w)
    function automatic longint tri_ramp(longint x, longint w);
        return (2 * x < w) ? (4 * x - w) : (3 * w - 4 * x);
    endfunction

    // num/den scaled to full scale, truncated toward zero, then clamped
    function automatic logic signed [mwo_pkg::SAMPLE_W-1:0] scale_ratio(longint num,
                                                                       longint den);
        longint s;
        s = (num * longint'(mwo_pkg::FULL_SCALE)) / den;
        if (s > longint'(mwo_pkg::FULL_SCALE))
            s = longint'(mwo_pkg::FULL_SCALE);
        if (s < -longint'(mwo_pkg::FULL_SCALE))
            s = -longint'(mwo_pkg::FULL_SCALE);
        return mwo_pkg::SAMPLE_W'(s);
    endfunction

    // Advance the voice by one request and return the sample it produces
    function automatic logic signed [mwo_pkg::SAMPLE_W-1:0] step_voice(
        logic [mwo_pkg::STEP_W-1:0] phase_step,
        logic [mwo_pkg::WAVE_W-1:0] waveform,
        logic                       restart
    );
        longint unit;
        longint aligned;
        longint t;
        longint d;
        longint w;
        bit     wrapped;
        logic   feedback;
        unit = longint'(1) << mwo_pkg::PHASE_BITS;
        if (restart)
        begin
            voice_phase = 0;
            voice_level = mwo_pkg::NOISE_SILENT;
            voice_lfsr  = mwo_pkg::NOISE_SEED;
        end
        if (mwo_pkg::PHASE_BITS >= mwo_pkg::STEP_W)
            aligned = longint'(phase_step) << (mwo_pkg::PHASE_BITS >= mwo_pkg::STEP_W ?
                      mwo_pkg::PHASE_BITS - mwo_pkg::STEP_W : 0);
        else
            aligned = longint'(phase_step) >> (mwo_pkg::PHASE_BITS < mwo_pkg::STEP_W ?
                      mwo_pkg::STEP_W - mwo_pkg::PHASE_BITS : 0);
        voice_phase = voice_phase + aligned;
        wrapped     = (voice_phase >= unit);
        if (wrapped)
            voice_phase = voice_phase - unit;

        // Noise shifts only on a wrap while selected
        if (waveform == mwo_pkg::WF_NOISE && wrapped)
        begin
            feedback    = voice_lfsr[0] ^ voice_lfsr[1];
            voice_lfsr  = {feedback, voice_lfsr[mwo_pkg::LFSR_W-1:1]};
            voice_level = voice_lfsr[0] ? mwo_pkg::NOISE_HIGH : mwo_pkg::NOISE_LOW;
        end

        t = voice_phase;
        case (waveform)
            mwo_pkg::WF_TRIANGLE: return scale_ratio(tri_ramp(t, unit), unit);
            mwo_pkg::WF_TILTED:
            begin
                if (8 * t < 7 * unit)
                    return scale_ratio(16 * t - 7 * unit, 7 * unit);
                return scale_ratio(16 * t - 15 * unit, unit);
            end
            mwo_pkg::WF_SAW:    return scale_ratio(2 * t - unit, unit);
            mwo_pkg::WF_SQUARE: return (2 * t < unit) ? mwo_pkg::FULL_SCALE : NEG_FULL;
            mwo_pkg::WF_PULSE:  return (4 * t < unit) ? mwo_pkg::FULL_SCALE : NEG_FULL;
            mwo_pkg::WF_ORGAN:
                return scale_ratio(tri_ramp(t, unit) + tri_ramp((2 * t) % unit, unit),
                                   2 * unit);
            mwo_pkg::WF_PHASER:
            begin
                w = 24 * unit;
                d = 25 * t - 16 * unit;
                if (d >= w)
                    d = d - w;
                if (d < 0)
                    d = d + w;
                return scale_ratio(tri_ramp(d, w), w);
            end
            default:
            begin
                if (voice_level == mwo_pkg::NOISE_HIGH)
                    return mwo_pkg::FULL_SCALE;
                if (voice_level == mwo_pkg::NOISE_LOW)
                    return NEG_FULL;
                return ZERO_OUT;
            end
        endcase
    endfunction

    // Insert a random gap whenever the current burst runs out
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // Offer one request, wait for the handshake, record its expected sample
    task automatic send_request(
        logic [mwo_pkg::STEP_W-1:0]          phase_step,
        logic [mwo_pkg::WAVE_W-1:0]          waveform,
        logic                                restart,
        logic                                has_fixed,
        logic signed [mwo_pkg::SAMPLE_W-1:0] fixed_sample
    );
        logic signed [mwo_pkg::SAMPLE_W-1:0] predicted;
        pace_sender();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= phase_step;
        s_axis_tuser  <= {restart, waveform};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = step_voice(phase_step, waveform, restart);
        expected_samples.push_back(has_fixed ? fixed_sample : predicted);
        requests_taken++;
    endtask

    // Reset and request stream
    initial
    begin
        logic [mwo_pkg::STEP_W-1:0] step;
        logic [mwo_pkg::WAVE_W-1:0] wave;
        logic                       restart;
        voice_phase    = 0;
        voice_lfsr     = mwo_pkg::NOISE_SEED;
        voice_level    = mwo_pkg::NOISE_SILENT;
        requests_taken = 0;
        mismatch_count = 0;
        burst_left     = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
            send_request(directed_rows[i].phase_step, directed_rows[i].waveform,
                         directed_rows[i].restart, directed_rows[i].has_fixed,
                         directed_rows[i].fixed_sample);

        // Random requests, biased toward noise and step extremes
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            case ($urandom_range(0, 9))
                0:       step = '0;
                1:       step = mwo_pkg::STEP_W'($urandom_range(1, 15));
                2:       step = 16'hFFFF - mwo_pkg::STEP_W'($urandom_range(0, 15));
                3:       step = mwo_pkg::STEP_W'(1) << $urandom_range(0, mwo_pkg::STEP_W - 1);
                4:       step = 16'h8000;
                default: step = mwo_pkg::STEP_W'($urandom_range(0, 65535));
            endcase
            wave    = ($urandom_range(0, 9) < 3) ? mwo_pkg::WF_NOISE
                                                 : mwo_pkg::WAVE_W'($urandom_range(0, 7));
            restart = ($urandom_range(0, 31) == 0);
            send_request(step, wave, restart, 1'b0, ZERO_OUT);
        end
        s_axis_tvalid <= 1'b0;

        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Output-side stall patterns, with one long hold to back up the input
    initial
    begin
        int unsigned seg_len;
        int unsigned seg_mode;
        hold_done = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            seg_len  = $urandom_range(16, 160);
            seg_mode = $urandom_range(SINK_OPEN, SINK_STROBE);
            for (int i = 0; i < seg_len; i++)
            begin
                if (!hold_done && requests_taken >= HOLD_AFTER)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_done = 1;
                end
                case (seg_mode)
                    SINK_OPEN:   m_axis_tready <= 1'b1;
                    SINK_RANDOM: m_axis_tready <= $urandom_range(0, 1);
                    SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default:     m_axis_tready <= (i % 3 == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Compare each accepted sample with the oldest expectation
    always @(posedge clk)
    begin
        logic signed [mwo_pkg::SAMPLE_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("sample: none expected, got %0d", $signed(m_axis_tdata));
                mismatch_count++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (want !== $signed(m_axis_tdata))
                begin
                    $error("sample mismatch: expected %0d, got %0d", want,
                           $signed(m_axis_tdata));
                    mismatch_count++;
                end
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule
